[design/scmes_pkg.sv]
// Package for the minimum-energy seam core: widths, register codes,
// state encoding and the RGB distance function.
// No dependencies.
`default_nettype none
package scmes_pkg;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int CFG_W          = 7;
    localparam int COLOR_W        = 8;
    localparam int PIX_W          = 24;
    localparam int DIST_W         = 18;
    localparam int ENERGY_W       = 19;
    localparam int COST_W         = 25;
    localparam int SEAM_INDEX_W   = 6;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DIR    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_COST,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT,
        ST_TRACE
    } t_state;

    function automatic logic [DIST_W-1:0] rgb_dist(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [15:0] s0;
        logic [15:0] s1;
        logic [15:0] s2;
        d0 = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
        d1 = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
        d2 = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
        s0 = {8'd0, d0} * {8'd0, d0};
        s1 = {8'd0, d1} * {8'd0, d1};
        s2 = {8'd0, d2} * {8'd0, d2};
        return DIST_W'(s0) + DIST_W'(s1) + DIST_W'(s2);
    endfunction
endpackage
`default_nettype wire

[design/scmes_if.sv]
// Valid/ready channel interfaces for pixel requests and seam results.
// Depends on scmes_pkg.
`default_nettype none
interface scmes_pix_if;
    logic                              valid;
    logic                              ready;
    logic [scmes_pkg::COLOR_W-1:0]     red;
    logic [scmes_pkg::COLOR_W-1:0]     green;
    logic [scmes_pkg::COLOR_W-1:0]     blue;
    logic                              final_pixel;
    modport source(output valid, red, green, blue, final_pixel, input ready);
    modport sink(input valid, red, green, blue, final_pixel, output ready);
endinterface

interface scmes_seam_if;
    logic                                 valid;
    logic                                 ready;
    logic [scmes_pkg::SEAM_INDEX_W-1:0]   seam_index;
    logic                                 seam_end;
    modport source(output valid, seam_index, seam_end, input ready);
    modport sink(input valid, seam_index, seam_end, output ready);
endinterface
`default_nettype wire

[design/seam_carving_min_energy_seam_core.sv]
// Minimum-energy seam core: pixel and cost memories, sequencer, APB registers.
// Depends on scmes_pkg and scmes_if.
//
// Pixels load one per cycle in raster order; the request flagged final_pixel starts the
// seam search and no pixel is taken until the last seam index is in the output register.
// For each pixel the core makes 4 reads of the pixel memory for the dual-gradient energy,
// 3 reads of the cost memory (none on the far line) and one write, all through the single
// read port of each memory. The scan picks the first minimum, and tracing waits on any
// output stall. The output register holds the last index while the next image loads.
`default_nettype none
module seam_carving_min_energy_seam_core #(
    parameter int MAX_WIDTH  = scmes_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = scmes_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    scmes_pix_if.sink                              i_pix,
    scmes_seam_if.source                           o_seam,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [scmes_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [scmes_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [scmes_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int LW      = $clog2(MAX_DIM);
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int CW      = scmes_pkg::CFG_W;
    localparam int PW      = scmes_pkg::PIX_W;
    localparam int KW      = scmes_pkg::COST_W;
    localparam int EW      = scmes_pkg::ENERGY_W;

    logic [CW-1:0] r_cfg_w;
    logic [CW-1:0] r_cfg_h;
    logic          r_cfg_dir;

    scmes_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_load, n_load;
    logic [DW-1:0] r_w, n_w, r_h, n_h, r_lines, n_lines, r_span, n_span;
    logic          r_vert, n_vert;
    logic [LW-1:0] r_ln, n_ln;
    logic [DW-1:0] r_p, n_p;
    logic [2:0]    r_k, n_k;
    logic [PW-1:0] r_pa, n_pa;
    logic [EW-1:0] r_energy, n_energy;
    logic [KW-1:0] r_best, n_best;
    logic [LW-1:0] r_pos, n_pos, r_sel, n_sel;
    logic          r_out_valid, n_out_valid;
    logic [scmes_pkg::SEAM_INDEX_W-1:0] r_out_idx, n_out_idx;
    logic          r_out_end, n_out_end;

    logic [PW-1:0] pix_mem [DEPTH];
    logic [KW-1:0] cost_mem [DEPTH];
    logic [PW-1:0] r_pix_rd;
    logic [KW-1:0] r_cost_rd;

    logic          pix_we;
    logic          cost_we;
    logic [KW-1:0] cost_wdata;
    logic [AW-1:0] mem_addr;
    logic [CW-1:0] cw_clamp, ch_clamp;
    logic [DW-1:0] cw, ch;
    logic          apb_wr;

    logic [LW-1:0] pos, cur_r, cur_c, w_last, h_last, span_last, lines_last;
    logic [LW-1:0] c_left, c_right, r_up, r_dn, p_left, p_right, t_left, t_right, cap;
    logic [LW-1:0] a_r, a_c, l_ln, l_pos;
    logic          use_line;
    logic          out_free;
    logic [scmes_pkg::DIST_W-1:0] pair_dist;

    // configuration registers
    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= CW'(64);
            r_cfg_h   <= CW'(64);
            r_cfg_dir <= 1'b0;
        end else if (apb_wr) begin
            unique case (paddr[3:2])
                scmes_pkg::REG_WIDTH:  r_cfg_w   <= pwdata[CW-1:0];
                scmes_pkg::REG_HEIGHT: r_cfg_h   <= pwdata[CW-1:0];
                scmes_pkg::REG_DIR:    r_cfg_dir <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            scmes_pkg::REG_WIDTH:  prdata = scmes_pkg::APB_DATA_W'(r_cfg_w);
            scmes_pkg::REG_HEIGHT: prdata = scmes_pkg::APB_DATA_W'(r_cfg_h);
            scmes_pkg::REG_DIR:    prdata = scmes_pkg::APB_DATA_W'(r_cfg_dir);
            default:               prdata = '0;
        endcase
    end

    // clamp image size
    always_comb begin
        if (r_cfg_w < CW'(2))              cw_clamp = CW'(2);
        else if (r_cfg_w > CW'(MAX_WIDTH)) cw_clamp = CW'(MAX_WIDTH);
        else                               cw_clamp = r_cfg_w;
        if (r_cfg_h < CW'(2))               ch_clamp = CW'(2);
        else if (r_cfg_h > CW'(MAX_HEIGHT)) ch_clamp = CW'(MAX_HEIGHT);
        else                                ch_clamp = r_cfg_h;
        cw = DW'(cw_clamp);
        ch = DW'(ch_clamp);
    end

    // neighbor positions
    always_comb begin
        pos        = r_p[LW-1:0];
        cur_r      = r_vert ? r_ln : pos;
        cur_c      = r_vert ? pos : r_ln;
        w_last     = LW'(r_w - 1'b1);
        h_last     = LW'(r_h - 1'b1);
        span_last  = LW'(r_span - 1'b1);
        lines_last = LW'(r_lines - 1'b1);
        c_left     = (cur_c == '0) ? w_last : cur_c - 1'b1;
        c_right    = (cur_c == w_last) ? '0 : cur_c + 1'b1;
        r_up       = (cur_r == '0) ? h_last : cur_r - 1'b1;
        r_dn       = (cur_r == h_last) ? '0 : cur_r + 1'b1;
        p_left     = (pos == '0) ? pos : pos - 1'b1;
        p_right    = (pos == span_last) ? pos : pos + 1'b1;
        t_left     = (r_pos == '0) ? r_pos : r_pos - 1'b1;
        t_right    = (r_pos == span_last) ? r_pos : r_pos + 1'b1;
        cap        = LW'(r_p - 1'b1);
    end

    // shared address generator
    always_comb begin
        a_r      = cur_r;
        a_c      = cur_c;
        l_ln     = '0;
        l_pos    = '0;
        use_line = 1'b0;
        unique case (r_state)
            scmes_pkg::ST_PIX: begin
                if (r_k == 3'd0)      a_c = c_left;
                else if (r_k == 3'd1) a_c = c_right;
                else if (r_k == 3'd2) a_r = r_up;
                else                  a_r = r_dn;
            end
            scmes_pkg::ST_COST: begin
                use_line = 1'b1;
                l_ln     = r_ln + 1'b1;
                if (r_k == 3'd1)      l_pos = p_left;
                else if (r_k == 3'd2) l_pos = p_right;
                else                  l_pos = pos;
            end
            scmes_pkg::ST_WRITE: begin
                use_line = 1'b1;
                l_ln     = r_ln;
                l_pos    = pos;
            end
            scmes_pkg::ST_SCAN: begin
                use_line = 1'b1;
                l_pos    = pos;
            end
            scmes_pkg::ST_TRACE: begin
                use_line = 1'b1;
                l_ln     = r_ln;
                if (r_k == 3'd1)      l_pos = t_left;
                else if (r_k == 3'd2) l_pos = t_right;
                else                  l_pos = r_pos;
            end
            default: ;
        endcase
        if (use_line) begin
            a_r = r_vert ? l_ln : l_pos;
            a_c = r_vert ? l_pos : l_ln;
        end
        mem_addr = AW'(AW'(a_r) * AW'(r_w) + AW'(a_c));
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            pix_mem[r_load] <= {i_pix.red, i_pix.green, i_pix.blue};
        end
        r_pix_rd <= pix_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            cost_mem[mem_addr] <= cost_wdata;
        end
        r_cost_rd <= cost_mem[mem_addr];
    end

    // sequencer
    assign i_pix.ready       = (r_state == scmes_pkg::ST_IDLE);
    assign out_free          = !r_out_valid || o_seam.ready;
    assign pair_dist         = scmes_pkg::rgb_dist(r_pa, r_pix_rd);
    assign cost_wdata        = r_best + KW'(r_energy);
    assign o_seam.valid      = r_out_valid;
    assign o_seam.seam_index = r_out_idx;
    assign o_seam.seam_end   = r_out_end;

    always_comb begin
        n_state     = r_state;
        n_load      = r_load;
        n_w         = r_w;
        n_h         = r_h;
        n_lines     = r_lines;
        n_span      = r_span;
        n_vert      = r_vert;
        n_ln        = r_ln;
        n_p         = r_p;
        n_k         = r_k;
        n_pa        = r_pa;
        n_energy    = r_energy;
        n_best      = r_best;
        n_pos       = r_pos;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !o_seam.ready;
        n_out_idx   = r_out_idx;
        n_out_end   = r_out_end;
        pix_we      = 1'b0;
        cost_we     = 1'b0;
        unique case (r_state)
            scmes_pkg::ST_IDLE: begin
                if (i_pix.valid) begin
                    pix_we = 1'b1;
                    if (i_pix.final_pixel) begin
                        n_load  = '0;
                        n_w     = cw;
                        n_h     = ch;
                        n_vert  = !r_cfg_dir;
                        n_lines = r_cfg_dir ? cw : ch;
                        n_span  = r_cfg_dir ? ch : cw;
                        n_ln    = r_cfg_dir ? LW'(cw - 1'b1) : LW'(ch - 1'b1);
                        n_p     = '0;
                        n_k     = '0;
                        n_state = scmes_pkg::ST_PIX;
                    end else begin
                        n_load = (r_load == AW'(DEPTH - 1)) ? '0 : r_load + 1'b1;
                    end
                end
            end
            scmes_pkg::ST_PIX: begin
                n_k = r_k + 1'b1;
                if (r_k == 3'd1 || r_k == 3'd3) n_pa = r_pix_rd;
                if (r_k == 3'd2) n_energy = EW'(pair_dist);
                if (r_k == 3'd4) begin
                    n_energy = r_energy + EW'(pair_dist);
                    n_k      = '0;
                    if (r_ln == lines_last) begin
                        n_best  = '0;
                        n_state = scmes_pkg::ST_WRITE;
                    end else begin
                        n_state = scmes_pkg::ST_COST;
                    end
                end
            end
            scmes_pkg::ST_COST: begin
                n_k = r_k + 1'b1;
                if (r_k == 3'd1) n_best = r_cost_rd;
                else if (r_k != 3'd0 && r_cost_rd < r_best) n_best = r_cost_rd;
                if (r_k == 3'd3) begin
                    n_k     = '0;
                    n_state = scmes_pkg::ST_WRITE;
                end
            end
            scmes_pkg::ST_WRITE: begin
                cost_we = 1'b1;
                n_k     = '0;
                n_state = scmes_pkg::ST_PIX;
                if (pos == span_last) begin
                    n_p = '0;
                    if (r_ln == '0) n_state = scmes_pkg::ST_SCAN;
                    else            n_ln    = r_ln - 1'b1;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            scmes_pkg::ST_SCAN: begin
                n_k = 3'd1;
                if (r_p < r_span) n_p = r_p + 1'b1;
                if (r_k != 3'd0) begin
                    if (cap == '0 || r_cost_rd < r_best) begin
                        n_best = r_cost_rd;
                        n_pos  = cap;
                    end
                    if (cap == span_last) n_state = scmes_pkg::ST_EMIT;
                end
            end
            scmes_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = scmes_pkg::SEAM_INDEX_W'(r_pos);
                    n_out_end   = (r_ln == lines_last);
                    n_k         = '0;
                    if (r_ln == lines_last) begin
                        n_state = scmes_pkg::ST_IDLE;
                    end else begin
                        n_ln    = r_ln + 1'b1;
                        n_state = scmes_pkg::ST_TRACE;
                    end
                end
            end
            scmes_pkg::ST_TRACE: begin
                n_k = r_k + 1'b1;
                if (r_k == 3'd1) begin
                    n_best = r_cost_rd;
                    n_sel  = r_pos;
                end else if (r_k == 3'd2) begin
                    if (r_cost_rd < r_best) begin
                        n_best = r_cost_rd;
                        n_sel  = t_left;
                    end
                end else if (r_k == 3'd3) begin
                    n_pos   = (r_cost_rd < r_best) ? t_right : r_sel;
                    n_k     = '0;
                    n_state = scmes_pkg::ST_EMIT;
                end
            end
            default: n_state = scmes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= scmes_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load      <= '0;
            r_k         <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_load      <= n_load;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_w       <= n_w;
        r_h       <= n_h;
        r_lines   <= n_lines;
        r_span    <= n_span;
        r_vert    <= n_vert;
        r_ln      <= n_ln;
        r_p       <= n_p;
        r_pa      <= n_pa;
        r_energy  <= n_energy;
        r_best    <= n_best;
        r_sel     <= n_sel;
        r_out_idx <= n_out_idx;
        r_out_end <= n_out_end;
    end

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && i_pix.final_pixel)
        |=> (r_state == scmes_pkg::ST_PIX && r_load == '0 && r_k == '0))
        else $error("seam search did not start after final pixel");

    a_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scmes_pkg::ST_PIX)
        |-> (r_w >= DW'(2) && r_w <= DW'(MAX_WIDTH) && r_h >= DW'(2)
             && r_h <= DW'(MAX_HEIGHT)))
        else $error("image size outside clamped range");

    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cost_we |-> (r_p < r_span && r_ln <= lines_last))
        else $error("cost write outside image");

    a_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scmes_pkg::ST_TRACE || r_state == scmes_pkg::ST_EMIT)
        |-> (DW'(r_pos) < r_span))
        else $error("seam position outside span");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scmes_pkg::ST_EMIT && out_free)
        |=> r_out_valid)
        else $error("seam index dropped");
endmodule
`default_nettype wire
